/* rtl/core/plid_pkg.sv */
// shared command and status codes for the positional list
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned PositionWidth = 8;
  localparam int unsigned CountWidth    = 5;

endpackage

`default_nettype wire

/* rtl/core/positional_list_insert_delete.sv */
// positional list: entry store in a single-port-write memory with a shifting sequencer
// commands: one item at a time; in_stall holds off a new command until the result of the
// previous one is registered at the output
// the shift loop moves one entry at a time, a read and then a write,
// through the single memory read port with its registered read data
// reset: synchronous, clears the list to empty and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic [2:0]                               cmd,
  input  wire logic signed [plid_pkg::ValueWidth-1:0]   value_in,
  input  wire logic [plid_pkg::PositionWidth-1:0]       position,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic [1:0]                                    status,
  output logic [plid_pkg::CountWidth-1:0]               count,
  output logic signed [plid_pkg::ValueWidth-1:0]        value_out
);

  localparam int unsigned IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = plid_pkg::PositionWidth + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_MOVE,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_VAL,
    S_DEL_CHK,
    S_DEL_MOVE,
    S_FINISH
  } state_t;

  state_t                               state;
  plid_pkg::cmd_t                       op;
  logic [plid_pkg::ValueWidth-1:0]      val;
  logic [CW-1:0]                        k;
  logic [CW-1:0]                        idx;
  logic [CW-1:0]                        cnt;
  plid_pkg::status_t                    res_status;
  logic [plid_pkg::ValueWidth-1:0]      res_value;

  logic [plid_pkg::ValueWidth-1:0]      mem [CAPACITY];
  logic [plid_pkg::ValueWidth-1:0]      rd_data;
  logic                                 rd_en;
  logic [IW-1:0]                        rd_addr;
  logic                                 wr_en;
  logic [IW-1:0]                        wr_addr;
  logic [plid_pkg::ValueWidth-1:0]      wr_data;

  logic                                 accept;
  logic [PW-1:0]                        pos_ext;
  logic [PW-1:0]                        cnt_ext;
  logic [CW-1:0]                        pos_idx;
  logic                                 full;
  logic                                 empty;
  logic                                 more_behind;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign pos_ext     = PW'(position);
  assign cnt_ext     = PW'(cnt);
  assign pos_idx     = CW'(position - 8'd1);
  assign full        = (cnt == CW'(CAPACITY));
  assign empty       = (cnt == '0);
  assign more_behind = ((CW + 1)'(idx) + (CW + 1)'(1)) < (CW + 1)'(cnt);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = IW'(idx);
    wr_data = rd_data;
    unique case (state)
      S_INS_CHK: begin
        rd_en   = (idx > k);
        rd_addr = IW'(idx - CW'(1));
      end
      S_INS_MOVE: begin
        wr_en = 1'b1;
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = IW'(k);
        wr_data = val;
      end
      S_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = IW'(k);
      end
      S_DEL_CHK: begin
        rd_en   = more_behind;
        rd_addr = IW'(idx + CW'(1));
      end
      S_DEL_MOVE: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= plid_pkg::cmd_t'(cmd);
            val        <= value_in;
            idx        <= cnt;
            res_value  <= '0;
            case (cmd) inside
              plid_pkg::CMD_INS_FRONT, plid_pkg::CMD_INS_END, plid_pkg::CMD_INS_AT: begin
                if (full) begin
                  res_status <= plid_pkg::ST_FULL;
                  state      <= S_FINISH;
                end else if (cmd == plid_pkg::CMD_INS_FRONT) begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= '0;
                  state      <= S_INS_CHK;
                end else if (cmd == plid_pkg::CMD_INS_END) begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= cnt;
                  state      <= S_INS_CHK;
                end else if (position == '0 || pos_ext > cnt_ext + PW'(1)) begin
                  res_status <= plid_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= pos_idx;
                  state      <= S_INS_CHK;
                end
              end
              plid_pkg::CMD_DEL_FRONT, plid_pkg::CMD_DEL_END, plid_pkg::CMD_DEL_AT,
              plid_pkg::CMD_READ: begin
                if (empty) begin
                  res_status <= plid_pkg::ST_EMPTY;
                  state      <= S_FINISH;
                end else if (cmd == plid_pkg::CMD_DEL_FRONT) begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= '0;
                  state      <= S_DEL_RD;
                end else if (cmd == plid_pkg::CMD_DEL_END) begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= cnt - CW'(1);
                  state      <= S_DEL_RD;
                end else if (position == '0 || pos_ext > cnt_ext) begin
                  res_status <= plid_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= plid_pkg::ST_OK;
                  k          <= pos_idx;
                  state      <= S_DEL_RD;
                end
              end
              default: begin
                res_status <= plid_pkg::ST_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_INS_CHK: begin
          state <= (idx > k) ? S_INS_MOVE : S_INS_PUT;
        end
        S_INS_MOVE: begin
          idx   <= idx - CW'(1);
          state <= S_INS_CHK;
        end
        S_INS_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_FINISH;
        end
        S_DEL_RD: begin
          state <= S_DEL_VAL;
        end
        S_DEL_VAL: begin
          res_value <= rd_data;
          idx       <= k;
          state     <= (op == plid_pkg::CMD_READ) ? S_FINISH : S_DEL_CHK;
        end
        S_DEL_CHK: begin
          if (more_behind) begin
            state <= S_DEL_MOVE;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_FINISH;
          end
        end
        S_DEL_MOVE: begin
          idx   <= idx + CW'(1);
          state <= S_DEL_CHK;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            count     <= plid_pkg::CountWidth'(cnt);
            value_out <= res_value;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/plid_checker.sv */
// port-level checks for the positional list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module plid_checker (
  input wire logic                                     clk,
  input wire logic                                     rst,
  input wire logic                                     in_valid,
  input wire logic                                     in_stall,
  input wire logic [2:0]                               cmd,
  input wire logic signed [plid_pkg::ValueWidth-1:0]   value_in,
  input wire logic [plid_pkg::PositionWidth-1:0]       position,
  input wire logic                                     out_valid,
  input wire logic                                     out_stall,
  input wire logic [1:0]                               status,
  input wire logic [plid_pkg::CountWidth-1:0]          count,
  input wire logic signed [plid_pkg::ValueWidth-1:0]   value_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(count) && $stable(value_out))
    else $error("stalled item changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != plid_pkg::ST_OK |-> value_out == '0)
    else $error("failed command returned a value");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == plid_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with entries present");

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);

`default_nettype wire

/* tb/sv/positional_list_insert_delete_tb.sv */
// testbench for the positional list: random and directed commands checked against a predictor
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;
  localparam int unsigned Capacity      = 16;
  localparam int unsigned ValueWidth    = plid_pkg::ValueWidth;
  localparam int unsigned PositionWidth = plid_pkg::PositionWidth;
  localparam int unsigned CountWidth    = plid_pkg::CountWidth;
  localparam int          RandomItems   = 1200;
  localparam int          IdleLimit     = 4000;
  localparam int          LongHold      = 300;
  localparam int          Settle        = 80;
  localparam logic [2:0]  CmdUnused     = 3'd7;

  typedef enum {PhaseFill, PhaseDrain, PhaseMixed} phase_t;

  class list_scoreboard;
    typedef struct {
      plid_pkg::status_t st;
      logic [CountWidth-1:0] cnt;
      logic signed [ValueWidth-1:0] val;
    } reply_t;

    logic signed [ValueWidth-1:0] store [Capacity];
    int unsigned held;
    int errors;
    reply_t replies_due [$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void open_slot(int unsigned k, logic signed [ValueWidth-1:0] v);
      for (int unsigned i = held; i > k; i--) store[i] = store[i - 1];
      store[k] = v;
      held++;
    endfunction

    function logic signed [ValueWidth-1:0] close_slot(int unsigned k);
      logic signed [ValueWidth-1:0] v;
      v = store[k];
      for (int unsigned i = k; i + 1 < held; i++) store[i] = store[i + 1];
      held--;
      return v;
    endfunction

    function void note_command(logic [2:0] op, logic signed [ValueWidth-1:0] v,
                               logic [PositionWidth-1:0] pos);
      reply_t r;
      r.st = plid_pkg::ST_OK;
      r.val = '0;
      case (op) inside
        plid_pkg::CMD_INS_FRONT, plid_pkg::CMD_INS_END, plid_pkg::CMD_INS_AT: begin
          if (held >= Capacity) r.st = plid_pkg::ST_FULL;
          else if (op == plid_pkg::CMD_INS_FRONT) open_slot(0, v);
          else if (op == plid_pkg::CMD_INS_END) open_slot(held, v);
          else if (pos < 1 || pos > held + 1) r.st = plid_pkg::ST_RANGE;
          else open_slot(pos - 1, v);
        end
        plid_pkg::CMD_DEL_FRONT, plid_pkg::CMD_DEL_END, plid_pkg::CMD_DEL_AT,
        plid_pkg::CMD_READ: begin
          if (held == 0) r.st = plid_pkg::ST_EMPTY;
          else if (op == plid_pkg::CMD_DEL_FRONT) r.val = close_slot(0);
          else if (op == plid_pkg::CMD_DEL_END) r.val = close_slot(held - 1);
          else if (pos < 1 || pos > held) r.st = plid_pkg::ST_RANGE;
          else if (op == plid_pkg::CMD_DEL_AT) r.val = close_slot(pos - 1);
          else r.val = store[pos - 1];
        end
        default: ;
      endcase
      r.cnt = CountWidth'(held);
      replies_due.push_back(r);
    endfunction

    task check_result(logic [1:0] st, logic [CountWidth-1:0] cnt,
                      logic signed [ValueWidth-1:0] val);
      reply_t r;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item: status %0d count %0d value %0d",
                                  st, cnt, val));
        return;
      end
      r = replies_due.pop_front();
      if (st !== r.st)
        report_mismatch($sformatf("status %0d, expected %s", st, r.st.name()));
      if (cnt !== r.cnt)
        report_mismatch($sformatf("count %0d, expected %0d", cnt, r.cnt));
      if (val !== r.val)
        report_mismatch($sformatf("value_out %0d, expected %0d", val, r.val));
    endtask

    function int unsigned outstanding();
      return replies_due.size();
    endfunction

    task check_drained();
      if (replies_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [2:0] cmd;
  logic signed [ValueWidth-1:0] value_in;
  logic [PositionWidth-1:0] position;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [CountWidth-1:0] count;
  logic signed [ValueWidth-1:0] value_out;

  list_scoreboard sb = new();
  bit tx_idle;
  bit rx_idle;
  bit hold_request;
  int idle_cycles;

  positional_list_insert_delete #(.CAPACITY(Capacity)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .value_in(value_in), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .count(count), .value_out(value_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_command(logic [2:0] op, logic signed [ValueWidth-1:0] v,
                              logic [PositionWidth-1:0] pos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    value_in <= v;
    position <= pos;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, v, pos);
  endtask

  function automatic logic [PositionWidth-1:0] pick_position(int unsigned hi);
    if ($urandom_range(0, 9) < 7 && hi >= 1) return PositionWidth'($urandom_range(1, hi));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PositionWidth'(hi + 1);
      2: return '1;
      default: return PositionWidth'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(phase_t mode);
    int r;
    int ins_pct;
    logic [2:0] op;
    ins_pct = (mode == PhaseFill) ? 70 : (mode == PhaseDrain) ? 15 : 42;
    r = $urandom_range(0, 99);
    if (r < 2) op = CmdUnused;
    else if (r < 2 + ins_pct)
      op = 3'($urandom_range(plid_pkg::CMD_INS_FRONT, plid_pkg::CMD_INS_AT));
    else if (r < 17 + ins_pct) op = plid_pkg::CMD_READ;
    else op = 3'($urandom_range(plid_pkg::CMD_DEL_FRONT, plid_pkg::CMD_DEL_AT));
    send_command(op, pick_value(),
                 pick_position(op <= plid_pkg::CMD_INS_AT ? sb.held + 1 : sb.held));
  endtask

  // receiver: random stalls per item plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(status, count, value_out);
        if (rx_idle) stall_left = $urandom_range(0, 11);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end
      out_stall <= (stall_left > 0) || (hold_left > 0);
      if (stall_left > 0) stall_left--;
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("positional_list_insert_delete regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int phase_len;
    phase_t mode;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= plid_pkg::CMD_INS_FRONT;
    value_in <= '0;
    position <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list, range edges, extremes of value and position, unused command
    send_command(plid_pkg::CMD_READ, '0, 8'd1);
    send_command(plid_pkg::CMD_DEL_FRONT, '0, 8'd0);
    send_command(plid_pkg::CMD_DEL_END, '0, 8'd0);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd0);
    send_command(plid_pkg::CMD_INS_AT, 32'sd7, 8'd2);
    send_command(plid_pkg::CMD_INS_AT, 32'sd7, 8'd0);
    send_command(plid_pkg::CMD_INS_AT, 32'sh7fffffff, 8'd1);
    send_command(plid_pkg::CMD_INS_FRONT, 32'sh80000000, 8'd0);
    send_command(plid_pkg::CMD_INS_END, -32'sd1, 8'd255);
    send_command(plid_pkg::CMD_INS_AT, '0, 8'd4);
    send_command(plid_pkg::CMD_INS_AT, 32'sd5555, 8'd2);
    send_command(plid_pkg::CMD_INS_AT, 32'sd9, 8'd7);
    send_command(plid_pkg::CMD_READ, '0, 8'd0);
    send_command(plid_pkg::CMD_READ, '0, 8'd6);
    send_command(plid_pkg::CMD_READ, '0, 8'd255);
    send_command(plid_pkg::CMD_READ, '0, 8'd5);
    send_command(plid_pkg::CMD_READ, '0, 8'd1);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd0);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd6);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd3);
    send_command(CmdUnused, 32'sh5a5a5a5a, 8'd3);
    send_command(plid_pkg::CMD_DEL_FRONT, '0, 8'd0);
    send_command(plid_pkg::CMD_DEL_END, '0, 8'd0);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd1);
    send_command(plid_pkg::CMD_DEL_AT, '0, 8'd1);

    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      phase_len = $urandom_range(30, 90);
      case ($urandom_range(0, 2))
        0: mode = PhaseFill;
        1: mode = PhaseDrain;
        default: mode = PhaseMixed;
      endcase
      if (phase % 4 == 1) mode = PhaseFill;
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        tx_idle = 1'b0;
        hold_request = 1'b1;
      end
      if (phase == 3 || phase % 5 == 4) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      repeat (phase_len) begin
        send_random(mode);
        sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("positional_list_insert_delete regression: pass");
    end else begin
      $display("positional_list_insert_delete regression: fail");
    end
    $finish;
  end
endmodule
